[rtl/qns_pkg.sv]
// ----------------------------------------------------------------------------
// qns_pkg
// Types, register indexes and helper functions shared by the quantizing
// nearest-neighbor scaler.
// ----------------------------------------------------------------------------
package qns_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // register file layout
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 12;
  localparam logic [CFG_AW-1:0] REG_DEPTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_SCALE  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_WIDTH  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_HEIGHT = 2'd3;

  localparam logic [3:0]  DEPTH_RST  = 4'd8;
  localparam logic [11:0] SCALE_RST  = 12'd256;
  localparam logic [8:0]  WIDTH_RST  = 9'd256;
  localparam logic [8:0]  HEIGHT_RST = 9'd256;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // source indexes fit the 9-bit size registers
  localparam int IDX_W = 9;
  // divider numerator: coordinate with eight fraction bits set
  localparam int NUM_W = 12 + 8;
  localparam int DEN_W = 12;

  typedef struct packed {
    logic       cmd;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0] in_ch0;
    logic [7:0] in_ch1;
    logic [7:0] in_ch2;
  } qns_in_t;

  typedef struct packed {
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;
    logic       status;
  } qns_out_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [IDX_W-1:0] quo;
  } qns_div_res_t;

  // clamp the depth register to 1..8
  function automatic logic [3:0] eff_depth(input logic [3:0] d);
    logic [3:0] r;
    if (d == 4'd0) begin
      r = 4'd1;
    end else if (d > 4'd8) begin
      r = 4'd8;
    end else begin
      r = d;
    end
    return r;
  endfunction

  // keep the top d bits and scale them back up by the integer step 255 / (2^d - 1)
  function automatic logic [7:0] quant(input logic [7:0] p, input logic [3:0] d);
    logic [7:0]  shifted;
    logic [7:0]  step;
    logic [15:0] prod;
    shifted = p >> (4'd8 - d);
    case (d)
      4'd1:    step = 8'd255;
      4'd2:    step = 8'd85;
      4'd3:    step = 8'd36;
      4'd4:    step = 8'd17;
      4'd5:    step = 8'd8;
      4'd6:    step = 8'd4;
      4'd7:    step = 8'd2;
      default: step = 8'd1;
    endcase
    prod = shifted * step;
    return prod[7:0];
  endfunction

endpackage

[rtl/qns_frame_mem.sv]
// ----------------------------------------------------------------------------
// qns_frame_mem
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module qns_frame_mem #(
  parameter int DEPTH = qns_pkg::MAX_WIDTH_DEF * qns_pkg::MAX_HEIGHT_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata
);

  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/qns_div.sv]
// ----------------------------------------------------------------------------
// qns_div
// Restoring divider for the source index, one quotient bit per cycle.
// Quotients of 512 and more are only flagged, since they always clamp.
// ----------------------------------------------------------------------------
module qns_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [qns_pkg::NUM_W-1:0]      num,
  input  logic [qns_pkg::DEN_W-1:0]      den,
  output qns_pkg::qns_div_res_t          res
);

  localparam int IW = qns_pkg::IDX_W;
  localparam int DW = qns_pkg::DEN_W;
  localparam int HW = qns_pkg::NUM_W - IW;

  logic                  busy;
  logic                  done;
  logic                  ovf;
  logic [3:0]            cnt;
  logic [DW-1:0]         rem;
  logic [DW-1:0]         den_r;
  logic [IW-1:0]         qsh;
  logic [HW-1:0]         hi;
  logic                  hi_ovf;
  logic [DW:0]           trial;
  logic                  ge;

  assign hi     = num[qns_pkg::NUM_W-1:IW];
  assign hi_ovf = {{(DW-HW){1'b0}}, hi} >= den;
  assign trial  = {rem, qsh[IW-1]};
  assign ge     = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= !hi_ovf;
      done <= hi_ovf;
    end else if (busy) begin
      if (cnt == 4'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ovf   <= hi_ovf;
      den_r <= den;
      rem   <= {{(DW-HW){1'b0}}, hi};
      qsh   <= num[IW-1:0];
      cnt   <= 4'(IW);
    end else if (busy) begin
      rem <= ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      qsh <= {qsh[IW-2:0], ge};
      cnt <= cnt - 4'd1;
    end
  end

  assign res.done = done;
  assign res.ovf  = ovf;
  assign res.quo  = qsh;

endmodule

[rtl/quantize_and_nearest_scale.sv]
// ----------------------------------------------------------------------------
// quantize_and_nearest_scale
// Quantizes written pixels into a frame store and reads them back through a
// nearest-neighbor scaled coordinate map.
// ----------------------------------------------------------------------------
//  port      dir  handshake           payload
//  in_*      in   in_valid/in_stall    qns_in_t  (cmd, pos_x, pos_y, channels)
//  out_*     out  out_valid/out_stall  qns_out_t (channels, status)
//  cfg_*     in   cfg_we               cfg_addr register index, cfg_data
//
//  a write is stored in the decode state, which returns straight to idle; a read in
//  range runs two passes of the 9-step divider (column then row) plus one frame store
//  read; a read outside the scaled image goes from decode straight to the output state
//  rst is synchronous; the frame store is not cleared
//  the next item is taken while a result still waits in the output register;
//  a read stalls before loading it until the previous result has left
module quantize_and_nearest_scale #(
  parameter int MAX_WIDTH  = qns_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = qns_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  qns_pkg::qns_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output qns_pkg::qns_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [qns_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [qns_pkg::CFG_DW-1:0]    cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = qns_pkg::IDX_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_DIVX   = 3'd2;
  localparam logic [2:0] ST_DIVY   = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0]  state;
  logic [2:0]  state_next;

  logic [3:0]  depth_bits;
  logic [11:0] scale_q8;
  logic [8:0]  src_width;
  logic [8:0]  src_height;

  logic [8:0]  eff_w;
  logic [8:0]  eff_h;
  logic [20:0] nw_prod;
  logic [20:0] nh_prod;
  logic [12:0] nw;
  logic [12:0] nh;

  qns_pkg::qns_in_t      item;
  qns_pkg::qns_div_res_t div_res;
  logic                  div_start;
  logic [qns_pkg::NUM_W-1:0] div_num;
  logic [IW-1:0]         sx;
  logic [IW-1:0]         clamp_idx;
  logic [8:0]            clamp_lim;
  logic                  oor;
  logic                  read_oor;
  logic                  write_ok;
  logic [3:0]            d_eff;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [23:0]           mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [23:0]           mem_rdata;
  logic                  out_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_bits <= qns_pkg::DEPTH_RST;
      scale_q8   <= qns_pkg::SCALE_RST;
      src_width  <= qns_pkg::WIDTH_RST;
      src_height <= qns_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        qns_pkg::REG_DEPTH:  depth_bits <= cfg_data[3:0];
        qns_pkg::REG_SCALE:  scale_q8   <= cfg_data;
        qns_pkg::REG_WIDTH:  src_width  <= cfg_data[8:0];
        qns_pkg::REG_HEIGHT: src_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // sizes saturate at the frame store dimensions
  assign eff_w = ({4'd0, src_width} > 13'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : src_width;
  assign eff_h = ({4'd0, src_height} > 13'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : src_height;
  assign nw_prod = eff_w * scale_q8;
  assign nh_prod = eff_h * scale_q8;
  assign nw = nw_prod[20:8];
  assign nh = nh_prod[20:8];

  assign d_eff    = qns_pkg::eff_depth(depth_bits);
  assign write_ok = (item.pos_x < {3'd0, eff_w}) && (item.pos_y < {3'd0, eff_h});
  assign read_oor = (scale_q8 == 12'd0) || ({1'b0, item.pos_x} >= nw)
                    || ({1'b0, item.pos_y} >= nh);

  assign in_stall = (state != ST_IDLE);
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  // index clamp to the source size
  assign clamp_lim = (state == ST_DIVX) ? eff_w - 9'd1 : eff_h - 9'd1;
  assign clamp_idx = (div_res.ovf || div_res.quo > clamp_lim) ? clamp_lim : div_res.quo;

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = {item.pos_x, 8'hFF};
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (item.cmd == qns_pkg::CMD_WRITE) begin
          mem_we     = write_ok;
          state_next = ST_IDLE;
        end else if (read_oor) begin
          state_next = ST_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (div_res.done) begin
          div_start  = 1'b1;
          div_num    = {item.pos_y, 8'hFF};
          state_next = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_res.done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        mem_re     = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DECODE) begin
      oor <= read_oor;
    end
    if (state == ST_DIVX && div_res.done) begin
      sx <= clamp_idx;
    end
    if (state == ST_DIVY && div_res.done) begin
      mem_raddr <= AW'(AW'(clamp_idx) * AW'(MAX_WIDTH) + AW'(sx));
    end
  end

  assign mem_waddr = AW'(AW'(item.pos_y) * AW'(MAX_WIDTH) + AW'(item.pos_x));
  assign mem_wdata = {qns_pkg::quant(item.in_ch2, d_eff),
                      qns_pkg::quant(item.in_ch1, d_eff),
                      qns_pkg::quant(item.in_ch0, d_eff)};

  qns_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (scale_q8),
    .res   (div_res)
  );

  qns_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.status  <= oor;
      out_data.out_ch0 <= oor ? 8'd0 : mem_rdata[7:0];
      out_data.out_ch1 <= oor ? 8'd0 : mem_rdata[15:8];
      out_data.out_ch2 <= oor ? 8'd0 : mem_rdata[23:16];
    end
  end

`ifndef SYNTHESIS
  // divider results only come back while a read waits for them
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == ST_DIVX || state == ST_DIVY))
    else $error("divider done outside index states");

  // an out-of-range item never carries pixel data
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status) |->
      (out_data.out_ch0 == 8'd0 && out_data.out_ch1 == 8'd0 && out_data.out_ch2 == 8'd0))
    else $error("out-of-range result with nonzero pixel");

  // an in-range result is loaded only after the frame store read
  a_read_before_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !oor && $past(state) != ST_OUT) |->
      ($past(state) == ST_READ))
    else $error("in-range result without frame store read");
`endif

endmodule

[sim/tb_quantize_and_nearest_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quantize_and_nearest_scale
// Self-checking bench for the quantizing nearest-neighbor scaler. A directed
// table covers reset values, depth clamping, empty and saturated sizes, zero
// and extreme scales; random phases then reconfigure the block and mix pixel
// writes with scaled reads. Each read is checked field by field against the
// table or a local frame store model, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_quantize_and_nearest_scale;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned RAND_ITEMS    = 2000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned FB_W          = 256;
  localparam int unsigned FB_H          = 256;

  typedef enum logic [1:0] {STEP_REG, STEP_ITEM, STEP_READ_KNOWN} step_kind_t;

  typedef struct {
    step_kind_t                 kind;
    logic [qns_pkg::CFG_AW-1:0] idx;
    logic [qns_pkg::CFG_DW-1:0] val;
    qns_pkg::qns_in_t           item;
    qns_pkg::qns_out_t          want;
  } step_t;

  logic                       clk      = 1'b0;
  logic                       rst      = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  qns_pkg::qns_in_t           in_data  = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  qns_pkg::qns_out_t          out_data;
  logic                       cfg_we   = 1'b0;
  logic [qns_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [qns_pkg::CFG_DW-1:0] cfg_data = '0;

  // local copy of the registers and the frame store
  logic [3:0]  m_depth;
  logic [11:0] m_scale;
  logic [8:0]  m_width;
  logic [8:0]  m_height;
  logic [23:0] pix_store [FB_W*FB_H];
  bit          pix_set   [FB_W*FB_H];

  qns_pkg::qns_out_t pixels_due [$];
  int          fail_count   = 0;
  int          results_seen = 0;
  int unsigned cycles       = 0;
  int unsigned rand_items   = 0;
  bit          no_gaps      = 1'b0;

  quantize_and_nearest_scale i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] reduce_depth(input logic [7:0] p, input logic [3:0] d_raw);
    int unsigned d;
    d = (d_raw == 4'd0) ? 1 : (d_raw > 4'd8) ? 8 : d_raw;
    return 8'((p >> (8 - d)) * (255 / ((1 << d) - 1)));
  endfunction

  function automatic int unsigned clip(input logic [8:0] v, input int unsigned top);
    return (v > top) ? top : v;
  endfunction

  // largest source index whose scaled start does not pass the coordinate
  function automatic int unsigned nearest_src(input int unsigned c, input int unsigned s,
                                              input int unsigned n);
    int unsigned i;
    i = ((c + 1) * 256 - 1) / s;
    return (i > n - 1) ? n - 1 : i;
  endfunction

  function automatic bit map_read(input logic [11:0] x, input logic [11:0] y,
                                  output int unsigned addr);
    int unsigned w, h, s;
    w = clip(m_width, FB_W);
    h = clip(m_height, FB_H);
    s = m_scale;
    addr = 0;
    if (s == 0 || x >= ((w * s) >> 8) || y >= ((h * s) >> 8)) return 1'b0;
    addr = nearest_src(y, s, h) * FB_W + nearest_src(x, s, w);
    return 1'b1;
  endfunction

  function automatic qns_pkg::qns_out_t scale_lookup(input qns_pkg::qns_in_t it);
    qns_pkg::qns_out_t r;
    int unsigned       addr;
    r = '0;
    r.status = 1'b1;
    if (map_read(it.pos_x, it.pos_y, addr)) begin
      {r.out_ch2, r.out_ch1, r.out_ch0} = pix_store[addr];
      r.status = 1'b0;
    end
    return r;
  endfunction

  function automatic step_t reg_row(input logic [qns_pkg::CFG_AW-1:0] idx,
                                    input int unsigned val);
    step_t r;
    r = '{kind: STEP_REG, idx: idx, val: val[qns_pkg::CFG_DW-1:0], item: '0, want: '0};
    return r;
  endfunction

  function automatic step_t item_row(input logic cmd, input int unsigned x, input int unsigned y,
                                     input int unsigned c0, input int unsigned c1,
                                     input int unsigned c2);
    step_t r;
    r = '{kind: STEP_ITEM, idx: '0, val: '0, item: '0, want: '0};
    r.item = '{cmd: cmd, pos_x: x[11:0], pos_y: y[11:0],
               in_ch0: c0[7:0], in_ch1: c1[7:0], in_ch2: c2[7:0]};
    return r;
  endfunction

  function automatic step_t known_row(input int unsigned x, input int unsigned y,
                                      input int unsigned c0, input int unsigned c1,
                                      input int unsigned c2, input logic st);
    step_t r;
    r = item_row(qns_pkg::CMD_READ, x, y, 8'hA5, 8'h5A, 8'hC3);
    r.kind = STEP_READ_KNOWN;
    r.want = '{out_ch0: c0[7:0], out_ch1: c1[7:0], out_ch2: c2[7:0], status: st};
    return r;
  endfunction

  task automatic set_reg(input logic [qns_pkg::CFG_AW-1:0] idx, input int unsigned val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val[qns_pkg::CFG_DW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      qns_pkg::REG_DEPTH:  m_depth  = val[3:0];
      qns_pkg::REG_SCALE:  m_scale  = val[11:0];
      qns_pkg::REG_WIDTH:  m_width  = val[8:0];
      qns_pkg::REG_HEIGHT: m_height = val[8:0];
      default: ;
    endcase
  endtask

  // offer one item, then update the model once it is taken
  task automatic push_item(input qns_pkg::qns_in_t it, input bit known,
                           input qns_pkg::qns_out_t want);
    int unsigned addr;
    while (!no_gaps && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (it.cmd == qns_pkg::CMD_WRITE) begin
      if (it.pos_x < clip(m_width, FB_W) && it.pos_y < clip(m_height, FB_H)) begin
        addr = it.pos_y * FB_W + it.pos_x;
        pix_store[addr] = {reduce_depth(it.in_ch2, m_depth), reduce_depth(it.in_ch1, m_depth),
                           reduce_depth(it.in_ch0, m_depth)};
        pix_set[addr] = 1'b1;
      end
    end else begin
      pixels_due.push_back(known ? want : scale_lookup(it));
    end
  endtask

  // wait until every read has answered and a trailing write has landed
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_item();
    qns_pkg::qns_in_t it;
    qns_pkg::qns_in_t fill;
    int unsigned      w, h, s, nw, nh, addr, pick;
    w  = clip(m_width, FB_W);
    h  = clip(m_height, FB_H);
    s  = m_scale;
    nw = (w * s) >> 8;
    nh = (h * s) >> 8;
    it.in_ch0 = 8'($urandom_range(0, 255));
    it.in_ch1 = 8'($urandom_range(0, 255));
    it.in_ch2 = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 40 && w != 0 && h != 0) begin
      it.cmd   = qns_pkg::CMD_WRITE;
      it.pos_x = 12'($urandom_range(0, w - 1));
      it.pos_y = 12'($urandom_range(0, h - 1));
    end else if (pick < 45) begin
      it.cmd   = qns_pkg::CMD_WRITE;
      it.pos_x = 12'($urandom_range(0, 4095));
      it.pos_y = 12'($urandom_range(0, 4095));
    end else if (pick < 90 && nw != 0 && nh != 0) begin
      it.cmd   = qns_pkg::CMD_READ;
      it.pos_x = 12'($urandom_range(0, nw - 1));
      it.pos_y = 12'($urandom_range(0, nh - 1));
    end else begin
      it.cmd   = qns_pkg::CMD_READ;
      it.pos_x = 12'($urandom_range(0, 4095));
      it.pos_y = 12'($urandom_range(0, 4095));
    end
    // never read a source pixel that was not written yet
    if (it.cmd == qns_pkg::CMD_READ && map_read(it.pos_x, it.pos_y, addr) && !pix_set[addr])
    begin
      fill        = it;
      fill.cmd    = qns_pkg::CMD_WRITE;
      fill.pos_x  = 12'(addr % FB_W);
      fill.pos_y  = 12'(addr / FB_W);
      fill.in_ch0 = 8'($urandom_range(0, 255));
      push_item(fill, 1'b0, '0);
      rand_items++;
    end
    push_item(it, 1'b0, '0);
    if (it.cmd == qns_pkg::CMD_READ || (it.pos_x < w && it.pos_y < h)) rand_items++;
  endtask

  initial begin : stimulus
    step_t       plan [$];
    int unsigned span;
    int unsigned n;
    m_depth  = qns_pkg::DEPTH_RST;
    m_scale  = qns_pkg::SCALE_RST;
    m_width  = qns_pkg::WIDTH_RST;
    m_height = qns_pkg::HEIGHT_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setup: 8 bits, unit scale, full 256x256 source
    plan.push_back(item_row(qns_pkg::CMD_WRITE, 0, 0, 255, 0, 128));
    plan.push_back(known_row(0, 0, 255, 0, 128, 1'b0));
    plan.push_back(item_row(qns_pkg::CMD_WRITE, 255, 255, 1, 2, 3));
    plan.push_back(known_row(255, 255, 1, 2, 3, 1'b0));
    plan.push_back(known_row(256, 0, 0, 0, 0, 1'b1));
    plan.push_back(known_row(4095, 4095, 0, 0, 0, 1'b1));
    plan.push_back(item_row(qns_pkg::CMD_WRITE, 4095, 4095, 255, 255, 255));
    plan.push_back(item_row(qns_pkg::CMD_WRITE, 0, 256, 77, 77, 77));
    plan.push_back(reg_row(qns_pkg::REG_DEPTH, 1));
    plan.push_back(item_row(qns_pkg::CMD_WRITE, 1, 0, 128, 127, 255));
    plan.push_back(known_row(1, 0, 255, 0, 255, 1'b0));
    // depth zero behaves as one bit
    plan.push_back(reg_row(qns_pkg::REG_DEPTH, 0));
    plan.push_back(item_row(qns_pkg::CMD_WRITE, 2, 0, 200, 100, 0));
    plan.push_back(known_row(2, 0, 255, 0, 0, 1'b0));
    // depth above eight behaves as eight
    plan.push_back(reg_row(qns_pkg::REG_DEPTH, 15));
    plan.push_back(item_row(qns_pkg::CMD_WRITE, 3, 0, 7, 8, 9));
    plan.push_back(known_row(3, 0, 7, 8, 9, 1'b0));
    plan.push_back(reg_row(qns_pkg::REG_DEPTH, 3));
    plan.push_back(item_row(qns_pkg::CMD_WRITE, 4, 0, 255, 160, 31));
    plan.push_back(known_row(4, 0, 252, 180, 0, 1'b0));
    // zero scale leaves nothing to read
    plan.push_back(reg_row(qns_pkg::REG_SCALE, 0));
    plan.push_back(known_row(0, 0, 0, 0, 0, 1'b1));
    plan.push_back(reg_row(qns_pkg::REG_SCALE, 512));
    plan.push_back(known_row(511, 511, 1, 2, 3, 1'b0));
    plan.push_back(known_row(1, 1, 255, 0, 128, 1'b0));
    plan.push_back(known_row(512, 0, 0, 0, 0, 1'b1));
    // one pixel source blown up to 15x15
    plan.push_back(reg_row(qns_pkg::REG_WIDTH, 1));
    plan.push_back(reg_row(qns_pkg::REG_HEIGHT, 1));
    plan.push_back(reg_row(qns_pkg::REG_SCALE, 4095));
    plan.push_back(known_row(14, 14, 255, 0, 128, 1'b0));
    plan.push_back(known_row(15, 0, 0, 0, 0, 1'b1));
    // empty source: writes dropped, reads outside
    plan.push_back(reg_row(qns_pkg::REG_WIDTH, 0));
    plan.push_back(item_row(qns_pkg::CMD_WRITE, 0, 0, 9, 9, 9));
    plan.push_back(known_row(0, 0, 0, 0, 0, 1'b1));
    // oversized source saturates to the store size
    plan.push_back(reg_row(qns_pkg::REG_WIDTH, 511));
    plan.push_back(reg_row(qns_pkg::REG_HEIGHT, 300));
    plan.push_back(reg_row(qns_pkg::REG_SCALE, 256));
    plan.push_back(reg_row(qns_pkg::REG_DEPTH, 8));
    plan.push_back(item_row(qns_pkg::CMD_WRITE, 255, 255, 0, 255, 0));
    plan.push_back(item_row(qns_pkg::CMD_READ, 255, 255, 0, 0, 0));
    plan.push_back(item_row(qns_pkg::CMD_READ, 3, 0, 255, 255, 255));

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_REG) begin
        settle();
        set_reg(plan[i].idx, plan[i].val);
      end else begin
        push_item(plan[i].item, plan[i].kind == STEP_READ_KNOWN, plan[i].want);
      end
    end

    while (rand_items < RAND_ITEMS) begin
      settle();
      set_reg(qns_pkg::REG_DEPTH, $urandom_range(0, 15));
      case ($urandom_range(0, 19))
        0:       set_reg(qns_pkg::REG_SCALE, 0);
        1:       set_reg(qns_pkg::REG_SCALE, 1);
        2:       set_reg(qns_pkg::REG_SCALE, 4095);
        3:       set_reg(qns_pkg::REG_SCALE, $urandom_range(0, 4095));
        default: set_reg(qns_pkg::REG_SCALE, $urandom_range(96, 1024));
      endcase
      for (n = 0; n < 2; n++) begin
        case ($urandom_range(0, 9))
          0:       span = 256;
          1:       span = $urandom_range(257, 511);
          2:       span = $urandom_range(0, 1);
          3:       span = $urandom_range(0, 511);
          default: span = $urandom_range(1, 20);
        endcase
        set_reg(n == 0 ? qns_pkg::REG_WIDTH : qns_pkg::REG_HEIGHT, span);
      end
      span = $urandom_range(80, 200);
      for (n = 0; n < span && rand_items < RAND_ITEMS; n++) begin
        no_gaps = (rand_items >= 500 && rand_items < 800);
        random_item();
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // receiver: random stalls, one quiet stretch and one long hold-off
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 300) begin
        held = 1'b1;
        repeat (600) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      if (results_seen >= 500 && results_seen < 700) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 25);
      end
    end
  end

  task automatic flag(input string fld, input int unsigned want, input int unsigned got);
    $display("%0t: %s mismatch, expected %0d got %0d", $time, fld, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin : check_results
    qns_pkg::qns_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: result with no read pending, expected none got %0d %0d %0d status %0d",
                 $time, out_data.out_ch0, out_data.out_ch1, out_data.out_ch2, out_data.status);
        fail_count++;
      end else begin
        want = pixels_due.pop_front();
        if (out_data.out_ch0 !== want.out_ch0) flag("out_ch0", want.out_ch0, out_data.out_ch0);
        if (out_data.out_ch1 !== want.out_ch1) flag("out_ch1", want.out_ch1, out_data.out_ch1);
        if (out_data.out_ch2 !== want.out_ch2) flag("out_ch2", want.out_ch2, out_data.out_ch2);
        if (out_data.status !== want.status) flag("status", want.status, out_data.status);
      end
      results_seen <= results_seen + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
